// ===== src/cpts_pkg.sv =====
// Package with the constants, codes and state type of the task scheduler.
package cpts_pkg;

    // Slot table geometry and field widths.
    localparam int NUM_TASKS = 16;
    localparam int IDX_W     = 4;
    localparam int PRIO_W    = 4;

    // Priorities are saturated into 1..MAX_PRIORITY on a slot write.
    localparam logic [PRIO_W-1:0] MAX_PRIORITY = 4'd15;
    localparam logic [PRIO_W-1:0] MIN_PRIORITY = 4'd1;

    // Slot indexes used by the sequencer.
    localparam logic [IDX_W-1:0] IDLE_SLOT  = '0;
    localparam logic [IDX_W-1:0] FIRST_SLOT = IDX_W'(1);
    localparam logic [IDX_W-1:0] LAST_SLOT  = IDX_W'(NUM_TASKS - 1);

    // Operation codes of an input beat.
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DEC    = 5'b00010,
        S_SCAN   = 5'b00100,
        S_RELOAD = 5'b01000,
        S_FIN    = 5'b10000
    } state_t;

endpackage

// ===== src/counter_priority_task_scheduler_unit.sv =====
// Top level of the time-slice task scheduler: slot table, sequencer and result register.
//
// The block holds sixteen task slots in flip-flops and answers every input beat with one
// result beat. A slot write passes through the finish state to the result register. A
// tick that leaves the running task's slice above zero passes through the decrement and
// finish states. A tick that schedules walks the slot table through a single compare unit,
// one slot per cycle, and may follow the scan with a counter reload and a second scan. The
// input side is ready only while the sequencer is idle; a finished result may wait in the
// output register while the next beat is accepted.
module counter_priority_task_scheduler_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  logic                         operation,
    input  logic [cpts_pkg::IDX_W-1:0]   task_index,
    input  logic                         present,
    input  logic                         runnable,
    input  logic [cpts_pkg::PRIO_W-1:0]  priority_req,
    output logic                         result_valid,
    input  logic                         result_ready,
    output logic [cpts_pkg::IDX_W-1:0]   current_task,
    output logic                         switched,
    output logic                         reloaded,
    output logic [cpts_pkg::PRIO_W-1:0]  current_counter
);

    // Slot table.
    logic                          present_reg   [cpts_pkg::NUM_TASKS];
    logic                          runnable_reg  [cpts_pkg::NUM_TASKS];
    logic [cpts_pkg::PRIO_W-1:0]   priority_reg  [cpts_pkg::NUM_TASKS];
    logic [cpts_pkg::PRIO_W-1:0]   counter_reg   [cpts_pkg::NUM_TASKS];

    // Sequencer and scan registers.
    cpts_pkg::state_t              state_reg;
    logic [cpts_pkg::IDX_W-1:0]    ptr_reg;
    logic [cpts_pkg::IDX_W-1:0]    running_reg;
    logic [cpts_pkg::IDX_W-1:0]    before_reg;
    logic                          refill_reg;
    logic                          found_reg;
    logic [cpts_pkg::PRIO_W-1:0]   best_reg;
    logic [cpts_pkg::IDX_W-1:0]    pick_reg;

    // Result register.
    logic                          result_valid_reg;
    logic [cpts_pkg::IDX_W-1:0]    current_task_reg;
    logic                          switched_reg;
    logic                          reloaded_reg;
    logic [cpts_pkg::PRIO_W-1:0]   current_counter_reg;

    logic                          item_beat;
    logic                          write_ok;
    logic [cpts_pkg::PRIO_W-1:0]   prio_sat;
    logic [cpts_pkg::PRIO_W-1:0]   cnt_rd;
    logic [cpts_pkg::PRIO_W-1:0]   cnt_dec;
    logic                          cand;
    logic                          found_next;
    logic [cpts_pkg::PRIO_W-1:0]   best_next;
    logic [cpts_pkg::IDX_W-1:0]    pick_next;
    logic                          out_free;

    assign item_ready = (state_reg == cpts_pkg::S_IDLE);
    assign item_beat  = item_valid && item_ready;
    assign out_free   = !result_valid_reg || result_ready;

    // Write qualification and priority saturation.
    assign write_ok = (task_index != cpts_pkg::IDLE_SLOT)
                   && ({1'b0, task_index} < (cpts_pkg::IDX_W + 1)'(cpts_pkg::NUM_TASKS));
    always_comb
    begin
        prio_sat = priority_req;
        if (priority_req < cpts_pkg::MIN_PRIORITY)
        begin
            prio_sat = cpts_pkg::MIN_PRIORITY;
        end
        else if (priority_req > cpts_pkg::MAX_PRIORITY)
        begin
            prio_sat = cpts_pkg::MAX_PRIORITY;
        end
    end

    // Single read port of the counter table and the saturating decrement.
    assign cnt_rd  = counter_reg[ptr_reg];
    assign cnt_dec = (cnt_rd != '0) ? (cnt_rd - 1'b1) : cnt_rd;

    // Shared compare unit: larger-or-equal counter wins, so ties go to the lower slot.
    assign cand = present_reg[ptr_reg] && runnable_reg[ptr_reg]
               && (!found_reg || (cnt_rd >= best_reg));
    assign found_next = found_reg || cand;
    assign best_next  = cand ? cnt_rd : best_reg;
    assign pick_next  = cand ? ptr_reg : pick_reg;

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= cpts_pkg::S_IDLE;
            ptr_reg     <= cpts_pkg::IDLE_SLOT;
            running_reg <= cpts_pkg::IDLE_SLOT;
            before_reg  <= cpts_pkg::IDLE_SLOT;
            refill_reg  <= 1'b0;
            found_reg   <= 1'b0;
            best_reg    <= '0;
            pick_reg    <= cpts_pkg::IDLE_SLOT;
        end
        else
        begin
            unique case (state_reg)
                cpts_pkg::S_IDLE:
                begin
                    if (item_beat)
                    begin
                        before_reg <= running_reg;
                        refill_reg <= 1'b0;
                        found_reg  <= 1'b0;
                        pick_reg   <= cpts_pkg::IDLE_SLOT;
                        if (operation == cpts_pkg::OP_WRITE)
                        begin
                            ptr_reg   <= running_reg;
                            state_reg <= cpts_pkg::S_FIN;
                        end
                        else if (running_reg == cpts_pkg::IDLE_SLOT)
                        begin
                            ptr_reg   <= cpts_pkg::LAST_SLOT;
                            state_reg <= cpts_pkg::S_SCAN;
                        end
                        else
                        begin
                            ptr_reg   <= running_reg;
                            state_reg <= cpts_pkg::S_DEC;
                        end
                    end
                end
                cpts_pkg::S_DEC:
                begin
                    // Slice ran out: schedule, otherwise report the running task.
                    if (cnt_dec == '0)
                    begin
                        ptr_reg   <= cpts_pkg::LAST_SLOT;
                        state_reg <= cpts_pkg::S_SCAN;
                    end
                    else
                    begin
                        state_reg <= cpts_pkg::S_FIN;
                    end
                end
                cpts_pkg::S_SCAN:
                begin
                    found_reg <= found_next;
                    best_reg  <= best_next;
                    pick_reg  <= pick_next;
                    if (ptr_reg == cpts_pkg::FIRST_SLOT)
                    begin
                        if (found_next && (best_next == '0) && !refill_reg)
                        begin
                            ptr_reg   <= cpts_pkg::FIRST_SLOT;
                            state_reg <= cpts_pkg::S_RELOAD;
                        end
                        else
                        begin
                            running_reg <= found_next ? pick_next : cpts_pkg::IDLE_SLOT;
                            ptr_reg     <= found_next ? pick_next : cpts_pkg::IDLE_SLOT;
                            state_reg   <= cpts_pkg::S_FIN;
                        end
                    end
                    else
                    begin
                        ptr_reg <= ptr_reg - 1'b1;
                    end
                end
                cpts_pkg::S_RELOAD:
                begin
                    if (ptr_reg == cpts_pkg::LAST_SLOT)
                    begin
                        refill_reg <= 1'b1;
                        found_reg  <= 1'b0;
                        pick_reg   <= cpts_pkg::IDLE_SLOT;
                        state_reg  <= cpts_pkg::S_SCAN;
                    end
                    else
                    begin
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                end
                cpts_pkg::S_FIN:
                begin
                    if (out_free)
                    begin
                        state_reg <= cpts_pkg::S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= cpts_pkg::S_IDLE;
                end
            endcase
        end
    end

    // Slot table writes: slot writes, decrement and reload sweep share one write port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < cpts_pkg::NUM_TASKS; i++)
            begin
                present_reg[i]  <= 1'b0;
                runnable_reg[i] <= 1'b0;
                priority_reg[i] <= cpts_pkg::MIN_PRIORITY;
                counter_reg[i]  <= '0;
            end
        end
        else
        begin
            if (item_beat && (operation == cpts_pkg::OP_WRITE) && write_ok)
            begin
                present_reg[task_index]  <= present;
                runnable_reg[task_index] <= runnable;
                priority_reg[task_index] <= prio_sat;
                counter_reg[task_index]  <= '0;
            end
            else if (state_reg == cpts_pkg::S_DEC)
            begin
                counter_reg[ptr_reg] <= cnt_dec;
            end
            else if ((state_reg == cpts_pkg::S_RELOAD) && present_reg[ptr_reg])
            begin
                counter_reg[ptr_reg] <= priority_reg[ptr_reg];
            end
        end
    end

    // Result register: loaded when the sequencer finishes and the slot is free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg    <= 1'b0;
            current_task_reg    <= cpts_pkg::IDLE_SLOT;
            switched_reg        <= 1'b0;
            reloaded_reg        <= 1'b0;
            current_counter_reg <= '0;
        end
        else
        begin
            if ((state_reg == cpts_pkg::S_FIN) && out_free)
            begin
                result_valid_reg    <= 1'b1;
                current_task_reg    <= running_reg;
                switched_reg        <= (running_reg != before_reg);
                reloaded_reg        <= refill_reg;
                current_counter_reg <= cnt_rd;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid    = result_valid_reg;
    assign current_task    = current_task_reg;
    assign switched        = switched_reg;
    assign reloaded        = reloaded_reg;
    assign current_counter = current_counter_reg;

    // The idle task never holds a slice.
    a_idle_counter_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (current_task == cpts_pkg::IDLE_SLOT)) |-> (current_counter == '0))
        else $error("idle task reported with a nonzero counter");

    // Counters are reloaded at most once per beat.
    a_single_reload: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cpts_pkg::S_RELOAD) |-> !refill_reg)
        else $error("second counter reload within one beat");

    // An accepted beat keeps the input side busy on the next cycle.
    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        item_beat |=> !item_ready)
        else $error("input ready right after an accepted beat");

endmodule

// ===== tb/sv/sched_checker.sv =====
// Checker for the task scheduler: watches both channels, predicts each result beat and compares.
module sched_checker
    import cpts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_ready,
    input  logic              operation,
    input  logic [IDX_W-1:0]  task_index,
    input  logic              present,
    input  logic              runnable,
    input  logic [PRIO_W-1:0] priority_req,
    input  logic              result_valid,
    input  logic              result_ready,
    input  logic [IDX_W-1:0]  current_task,
    input  logic              switched,
    input  logic              reloaded,
    input  logic [PRIO_W-1:0] current_counter,
    output int                fail_count,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // One result beat of the scheduler.
    typedef struct packed {
        logic [IDX_W-1:0]  run_slot;
        logic              switched;
        logic              reloaded;
        logic [PRIO_W-1:0] slice_left;
    } sched_result_t;

    // Shadow copy of the slot table and the running task.
    logic              live_tab  [NUM_TASKS];
    logic              ready_tab [NUM_TASKS];
    logic [PRIO_W-1:0] prio_tab  [NUM_TASKS];
    logic [PRIO_W-1:0] slice_tab [NUM_TASKS];
    logic [IDX_W-1:0]  running;

    sched_result_t     expected_q[$];
    int                mismatches = 0;

    // Scan from the top slot down; the lowest index wins a tie. best is -1 if none can run.
    function automatic logic [IDX_W-1:0] find_best(output int best);
        logic [IDX_W-1:0] pick = IDLE_SLOT;
        best = -1;
        for (int i = NUM_TASKS - 1; i >= 1; i--) begin
            if (live_tab[i] && ready_tab[i] && int'(slice_tab[i]) >= best) begin
                best = int'(slice_tab[i]);
                pick = IDX_W'(i);
            end
        end
        return pick;
    endfunction

    // Choose the next task, refilling every present slot once if all slices are spent.
    function automatic logic choose_next();
        int   best;
        logic refilled = 1'b0;
        running = find_best(best);
        if (best == 0) begin
            for (int i = 1; i < NUM_TASKS; i++) begin
                if (live_tab[i])
                    slice_tab[i] = prio_tab[i];
            end
            refilled = 1'b1;
            running = find_best(best);
        end
        return refilled;
    endfunction

    // Apply one input beat to the shadow state and return the result it must cause.
    function automatic sched_result_t schedule_beat(input logic op,
                                                    input logic [IDX_W-1:0] idx,
                                                    input logic pres,
                                                    input logic run,
                                                    input logic [PRIO_W-1:0] prio);
        sched_result_t     r;
        logic [IDX_W-1:0]  was = running;
        logic [PRIO_W-1:0] p;
        logic              refilled = 1'b0;
        if (op == OP_WRITE) begin
            // Writes to the idle slot or past the table are dropped.
            if (idx != IDLE_SLOT && int'(idx) < NUM_TASKS) begin
                p = prio;
                if (p < MIN_PRIORITY)
                    p = MIN_PRIORITY;
                if (p > MAX_PRIORITY)
                    p = MAX_PRIORITY;
                live_tab[idx]  = pres;
                ready_tab[idx] = run;
                prio_tab[idx]  = p;
                slice_tab[idx] = '0;
            end
        end else if (running == IDLE_SLOT) begin
            refilled = choose_next();
        end else begin
            if (slice_tab[running] != '0)
                slice_tab[running] = slice_tab[running] - 1'b1;
            if (slice_tab[running] == '0)
                refilled = choose_next();
        end
        r.run_slot   = running;
        r.switched   = (running != was);
        r.reloaded   = refilled;
        r.slice_left = slice_tab[running];
        return r;
    endfunction

    // Compare one accepted result beat with the oldest expectation.
    task automatic check_result(input sched_result_t got);
        sched_result_t want;
        if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: result beat with nothing expected: task %0d sw %0b rl %0b cnt %0d",
                         $time, got.run_slot, got.switched, got.reloaded, got.slice_left);
        end else begin
            want = expected_q.pop_front();
            if (got.run_slot !== want.run_slot || got.switched !== want.switched ||
                got.reloaded !== want.reloaded || got.slice_left !== want.slice_left) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: expected task %0d sw %0b rl %0b cnt %0d, got %0d %0b %0b %0d",
                             $time, want.run_slot, want.switched, want.reloaded,
                             want.slice_left, got.run_slot, got.switched, got.reloaded,
                             got.slice_left);
            end
        end
    endtask

    // Results are checked before the new input beat is predicted in the same cycle.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < NUM_TASKS; i++) begin
                live_tab[i]  = 1'b0;
                ready_tab[i] = 1'b0;
                prio_tab[i]  = MIN_PRIORITY;
                slice_tab[i] = '0;
            end
            running = IDLE_SLOT;
            expected_q.delete();
            pending    <= 0;
            fail_count <= mismatches;
        end else begin
            if (result_valid && result_ready)
                check_result({current_task, switched, reloaded, current_counter});
            if (item_valid && item_ready)
                expected_q.push_back(schedule_beat(operation, task_index, present, runnable,
                                                   priority_req));
            pending    <= expected_q.size();
            fail_count <= mismatches;
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for the task scheduler: clock, reset, stimulus, stalls and the verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cpts_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int PHASE_BEATS    = 160;

    logic              clk;
    logic              rst_n;
    logic              item_valid;
    logic              item_ready;
    logic              operation;
    logic [IDX_W-1:0]  task_index;
    logic              present;
    logic              runnable;
    logic [PRIO_W-1:0] priority_req;
    logic              result_valid;
    logic              result_ready = 1'b0;
    logic [IDX_W-1:0]  current_task;
    logic              switched;
    logic              reloaded;
    logic [PRIO_W-1:0] current_counter;

    int fail_count;
    int pending;
    int send_idle_pct = 20;
    int recv_idle_pct = 80;
    int hold_req      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    counter_priority_task_scheduler_unit u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .operation       (operation),
        .task_index      (task_index),
        .present         (present),
        .runnable        (runnable),
        .priority_req    (priority_req),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .current_task    (current_task),
        .switched        (switched),
        .reloaded        (reloaded),
        .current_counter (current_counter)
    );

    sched_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .operation       (operation),
        .task_index      (task_index),
        .present         (present),
        .runnable        (runnable),
        .priority_req    (priority_req),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .current_task    (current_task),
        .switched        (switched),
        .reloaded        (reloaded),
        .current_counter (current_counter),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    // 10 ns clock.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Result side: random back-pressure, plus a long hold-off whenever one is requested.
    always @(posedge clk)
    begin
        if (hold_left != 0) begin
            result_ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (hold_seen != hold_req) begin
            hold_seen    <= hold_req;
            hold_left    <= HOLD_CYCLES;
            result_ready <= 1'b0;
        end else begin
            result_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on cycles in which neither channel moves a beat.
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one input beat after a random gap and hold it until it is taken.
    task automatic send_beat(input logic op, input logic [IDX_W-1:0] idx, input logic pres,
                             input logic run, input logic [PRIO_W-1:0] prio);
        while ($urandom_range(99) < send_idle_pct) begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid   <= 1'b1;
        operation    <= op;
        task_index   <= idx;
        present      <= pres;
        runnable     <= run;
        priority_req <= prio;
        do
            @(posedge clk);
        while (!item_ready);
    endtask

    // Mostly ticks; writes lean to short slices so that tasks run out and rotate often.
    task automatic send_random();
        logic [PRIO_W-1:0] prio;
        if ($urandom_range(99) < 65) begin
            send_beat(OP_TICK, IDX_W'($urandom_range(15)), 1'($urandom_range(1)),
                      1'($urandom_range(1)), PRIO_W'($urandom_range(15)));
        end else begin
            if ($urandom_range(99) < 50)
                prio = PRIO_W'($urandom_range(3));
            else
                prio = PRIO_W'($urandom_range(15));
            send_beat(OP_WRITE, IDX_W'($urandom_range(15)), $urandom_range(99) < 85,
                      $urandom_range(99) < 75, prio);
        end
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        item_valid   <= 1'b0;
        operation    <= OP_TICK;
        task_index   <= '0;
        present      <= 1'b0;
        runnable     <= 1'b0;
        priority_req <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, dropped and saturated writes, absent and blocked tasks.
        send_beat(OP_TICK,  4'd0,  1'b0, 1'b0, 4'd0);
        send_beat(OP_WRITE, 4'd0,  1'b1, 1'b1, 4'd9);
        send_beat(OP_WRITE, 4'd15, 1'b1, 1'b1, 4'd15);
        send_beat(OP_WRITE, 4'd1,  1'b1, 1'b1, 4'd0);
        send_beat(OP_WRITE, 4'd5,  1'b1, 1'b0, 4'd7);
        send_beat(OP_WRITE, 4'd6,  1'b0, 1'b1, 4'd3);
        send_beat(OP_TICK,  4'd0,  1'b0, 1'b0, 4'd0);
        // Rewrite the running task, then let its cleared slice force a reschedule.
        send_beat(OP_WRITE, 4'd15, 1'b1, 1'b1, 4'd2);
        repeat (4) send_beat(OP_TICK, 4'd15, 1'b1, 1'b1, 4'd15);
        // Equal slices after a refill: the lower slot must win.
        send_beat(OP_WRITE, 4'd10, 1'b1, 1'b1, 4'd4);
        send_beat(OP_WRITE, 4'd3,  1'b1, 1'b1, 4'd4);
        repeat (5) send_beat(OP_TICK, 4'd0, 1'b0, 1'b0, 4'd0);
        // Remove every runnable task so the idle slot takes over.
        send_beat(OP_WRITE, 4'd1,  1'b0, 1'b0, 4'd1);
        send_beat(OP_WRITE, 4'd15, 1'b0, 1'b0, 4'd1);
        send_beat(OP_WRITE, 4'd10, 1'b0, 1'b0, 4'd1);
        send_beat(OP_WRITE, 4'd3,  1'b0, 1'b1, 4'd1);
        repeat (2) send_beat(OP_TICK, 4'd0, 1'b0, 1'b0, 4'd0);

        // Random phases with different idling on each side; drain between phases.
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 0) begin
                send_idle_pct = 20;
                recv_idle_pct <= 80;
            end else if (ph == 1) begin
                send_idle_pct = 80;
                recv_idle_pct <= 20;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            for (int n = 0; n < PHASE_BEATS; n++) begin
                // Long result-side stall while input beats keep coming.
                if (ph == 2 && n == 40)
                    hold_req <= hold_req + 1;
                send_random();
            end
            item_valid <= 1'b0;
            @(posedge clk);
            while (pending != 0)
                @(posedge clk);
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
src/cpts_pkg.sv
src/counter_priority_task_scheduler_unit.sv
tb/sv/sched_checker.sv
tb/sv/tb.sv
